// ===== src/klht_pkg.sv =====
// Shared types, constants and the name normalizer for the keyed LRU hint table.
package klht_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int NAME_BYTES  = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_W      = 3;
	localparam int COUNT_W     = 4;
	localparam logic [31:0] CLOCK_SANE  = 32'd1700000000;
	localparam logic [31:0] TTL_DEFAULT = 32'd604800;

	typedef enum logic [1:0] {
		F_LOOKUP = 2'd0,
		F_UPSERT = 2'd1,
		F_EVICT  = 2'd2,
		F_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [255:0] name;
		logic [47:0]  addr;
		logic [7:0]   chan;
		logic         flag;
		logic [31:0]  used;
		logic [31:0]  mark;
	} rec_t;

	typedef struct packed {
		logic               ok;
		logic               found;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] dropped;
		logic [7:0]         chan;
		logic               flag;
		logic [31:0]        used;
		logic [31:0]        mark;
		logic [47:0]        addr;
	} res_t;

	// Zero every byte from the first zero byte on, and beyond NAME_BYTES.
	function automatic logic [255:0] norm_name(input logic [255:0] w);
		logic [255:0] o;
		logic         ended;
		o     = '0;
		ended = 1'b0;
		for (int b = 0; b < 32; b++) begin
			if (w[b*8 +: 8] == 8'd0 || b >= NAME_BYTES) ended = 1'b1;
			if (!ended) o[b*8 +: 8] = w[b*8 +: 8];
		end
		return o;
	endfunction

endpackage

// ===== src/klht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module klht_ram #(
	parameter int W = 8,
	parameter int D = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== src/keyed_lru_hint_table_top.sv =====
// Top level of the keyed LRU hint table: sequencer, record RAM and output register.
//
//  channel | signals                               | dir | transfer when
//  --------+---------------------------------------+-----+----------------------------
//  in      | in_valid, in_stall, func..max_age_secs| in  | in_valid && !in_stall
//  out     | out_valid, out_stall, ok..addr_out    | out | out_valid && !out_stall
//  cfg     | cfg_wr_en, cfg_wr_data                | in  | cfg_wr_en
//
// One item at a time; the record RAM (one read, one write per cycle, registered
// read data) sets the pace. Each stored entry is scanned in a scan and a check
// state; an upsert miss on a full table then moves the entries above the least
// recently used one down one slot, through a read and a write state per entry.
// Clear, rejected upserts and evicts with nothing stale go straight to finish.
// Reset clears count, sequencer and output valid; RAM contents are never
// read above the entry count, so no clearing pass is needed.
// A stalled output holds its result; the next item is taken meanwhile and
// waits in the finish state until the output register frees.
module keyed_lru_hint_table_top
	import klht_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   func,
	input  logic [63:0]  name_word0,
	input  logic [63:0]  name_word1,
	input  logic [63:0]  name_word2,
	input  logic [63:0]  name_word3,
	input  logic [47:0]  station_addr,
	input  logic [7:0]   chan_in,
	input  logic         flag_in,
	input  logic [31:0]  now_secs,
	input  logic [31:0]  max_age_secs,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         ok,
	output logic         found,
	output logic [2:0]   slot_index,
	output logic [3:0]   entry_count,
	output logic [3:0]   dropped_count,
	output logic [7:0]   chan_out,
	output logic         flag_out,
	output logic [31:0]  used_secs_out,
	output logic [31:0]  mark_secs_out,
	output logic [47:0]  addr_out
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] count_q;
	logic [31:0]      ttl_q;
	logic             out_valid_q;

	// per-item working registers
	func_t            func_q;
	logic [255:0]     name_q;
	logic [47:0]      addr_q;
	logic [7:0]       chan_q;
	logic             flag_q;
	logic [31:0]      now_q;
	logic [31:0]      cutoff_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] dst_q;
	logic [CNT_W-1:0] drop_q;
	logic [IDX_W-1:0] min_idx_q;
	logic [31:0]      min_used_q;
	res_t             res_q;
	res_t             out_q;

	// RAM port
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	rec_t             ram_wdata;
	logic [$bits(rec_t)-1:0] ram_rdata;
	rec_t             rd;

	logic [255:0] nm_in;
	logic         in_xfer;
	logic         in_empty;
	logic         in_short;
	logic         match;
	logic         refresh;
	logic         scan_more;
	logic         keep;
	logic         out_free;
	rec_t         new_rec;
	rec_t         upd_rec;
	res_t         res_init;
	res_t         res_fin;
	logic [IDX_W-1:0] idx_a;
	logic [IDX_W-1:0] prev_a;

	klht_ram #(.W($bits(rec_t)), .D(MAX_ENTRIES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_a),
		.rdata(ram_rdata)
	);

	function automatic res_t make_res(input rec_t r, input logic [IDX_W-1:0] i,
		input logic hit);
		res_t x;
		x         = '0;
		x.ok      = 1'b1;
		x.found   = hit;
		x.slot    = SLOT_W'(i);
		x.chan    = r.chan;
		x.flag    = r.flag;
		x.used    = r.used;
		x.mark    = r.mark;
		x.addr    = r.addr;
		return x;
	endfunction

	assign nm_in    = norm_name({name_word3, name_word2, name_word1, name_word0});
	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign in_empty = (nm_in[7:0] == 8'd0);
	// items finished without touching the RAM
	assign in_short = (func_t'(func) == F_CLEAR) ||
		(func_t'(func) == F_UPSERT && in_empty) ||
		(func_t'(func) == F_EVICT && !(now_secs > max_age_secs));

	assign rd        = rec_t'(ram_rdata);
	assign idx_a     = idx_q[IDX_W-1:0];
	assign prev_a    = IDX_W'(idx_q - CNT_W'(1));
	assign match     = (rd.name == name_q) && (rd.addr == addr_q);
	assign refresh   = (rd.flag != flag_q) ||
		((now_q > CLOCK_SANE) && ((now_q - rd.mark) > ttl_q));
	assign scan_more = (idx_q < count_q);
	assign keep      = !(rd.used < cutoff_q);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		new_rec      = '0;
		new_rec.name = name_q;
		new_rec.addr = addr_q;
		new_rec.chan = chan_q;
		new_rec.flag = flag_q;
		new_rec.used = now_q;
		new_rec.mark = now_q;
		upd_rec      = rd;
		upd_rec.chan = chan_q;
		upd_rec.flag = flag_q;
		upd_rec.used = now_q;
		upd_rec.mark = refresh ? now_q : rd.mark;
		res_init     = '0;
		res_init.ok  = !(func_t'(func) == F_UPSERT && in_empty);
		res_fin         = res_q;
		res_fin.count   = COUNT_W'(count_q);
		res_fin.dropped = COUNT_W'(drop_q);
	end

	// next state and RAM write control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_a;
		ram_wdata = new_rec;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) state_d = in_short ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				if (scan_more) begin
					state_d = S_CHECK;
				end else if (func_q == F_UPSERT) begin
					if (count_q < MAX_CNT) begin
						ram_we    = 1'b1;
						ram_waddr = IDX_W'(count_q);
						state_d   = S_DONE;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_CHECK: begin
				state_d = S_SCAN;
				case (func_q)
					F_LOOKUP: begin
						if (match) state_d = S_DONE;
					end
					F_UPSERT: begin
						if (match) begin
							ram_we    = 1'b1;
							ram_wdata = upd_rec;
							state_d   = S_DONE;
						end
					end
					F_EVICT: begin
						// compaction: dst never passes the read pointer
						if (keep) begin
							ram_we    = 1'b1;
							ram_waddr = IDX_W'(dst_q);
							ram_wdata = rd;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SHIFT_RD: begin
				if (idx_q < MAX_CNT) begin
					state_d = S_SHIFT_WR;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = LAST_IDX;
					state_d   = S_DONE;
				end
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = prev_a;
				ram_wdata = rd;
				state_d   = S_SHIFT_RD;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ttl_q       <= TTL_DEFAULT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) ttl_q <= cfg_wr_data;
			if (state_q == S_IDLE && in_xfer && func_t'(func) == F_CLEAR) count_q <= '0;
			if (state_q == S_SCAN && !scan_more) begin
				if (func_q == F_EVICT) count_q <= dst_q;
				if (func_q == F_UPSERT && count_q < MAX_CNT) count_q <= count_q + CNT_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					func_q   <= func_t'(func);
					name_q   <= nm_in;
					addr_q   <= station_addr;
					chan_q   <= chan_in;
					flag_q   <= flag_in;
					now_q    <= now_secs;
					cutoff_q <= now_secs - max_age_secs;
					idx_q    <= '0;
					dst_q    <= '0;
					drop_q   <= '0;
					res_q    <= res_init;
				end
			end
			S_SCAN: begin
				if (!scan_more && func_q == F_UPSERT) begin
					if (count_q < MAX_CNT) begin
						res_q <= make_res(new_rec, IDX_W'(count_q), 1'b0);
					end else begin
						idx_q <= CNT_W'(min_idx_q) + CNT_W'(1);
					end
				end
			end
			S_CHECK: begin
				idx_q <= idx_q + CNT_W'(1);
				case (func_q)
					F_LOOKUP: begin
						if (match) res_q <= make_res(rd, idx_a, 1'b1);
					end
					F_UPSERT: begin
						if (match) begin
							res_q <= make_res(upd_rec, idx_a, 1'b1);
						end else if (idx_q == '0 || rd.used < min_used_q) begin
							// strict compare keeps the lowest index on ties
							min_idx_q  <= idx_a;
							min_used_q <= rd.used;
						end
					end
					F_EVICT: begin
						if (keep) dst_q <= dst_q + CNT_W'(1);
						else drop_q <= drop_q + CNT_W'(1);
					end
					default: ;
				endcase
			end
			S_SHIFT_RD: begin
				if (!(idx_q < MAX_CNT)) res_q <= make_res(new_rec, LAST_IDX, 1'b0);
			end
			S_SHIFT_WR: begin
				idx_q <= idx_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q <= res_fin;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = out_q.ok;
	assign found         = out_q.found;
	assign slot_index    = out_q.slot;
	assign entry_count   = out_q.count;
	assign dropped_count = out_q.dropped;
	assign chan_out      = out_q.chan;
	assign flag_out      = out_q.flag;
	assign used_secs_out = out_q.used;
	assign mark_secs_out = out_q.mark;
	assign addr_out      = out_q.addr;

endmodule

// ===== src/klht_chk.sv =====
// Port-level assertions for the keyed LRU hint table, bound to the top level.
module klht_chk
	import klht_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       ok,
	input logic       found,
	input logic [3:0] entry_count,
	input logic [3:0] dropped_count
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn under stall");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= 4'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_reject_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> !found && dropped_count == 4'd0)
		else $error("rejected upsert reports a hit or drops");

	a_hit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> entry_count != 4'd0)
		else $error("hit reported on empty table");

endmodule

bind keyed_lru_hint_table_top klht_chk u_klht_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.ok           (ok),
	.found        (found),
	.entry_count  (entry_count),
	.dropped_count(dropped_count)
);

// ===== tb/sv/tb_keyed_lru_hint_table_top.sv =====
// Self-checking testbench for the keyed LRU hint table top level.
module tb_keyed_lru_hint_table_top
	import klht_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// One table operation as seen on the input channel.
	typedef struct {
		func_t       fn;
		logic [255:0] name;
		logic [47:0] addr;
		logic [7:0]  chan;
		logic        flag;
		logic [31:0] now;
		logic [31:0] max_age;
	} op_t;

	// Scoreboard: shadow copy of the table plus a queue of predicted results.
	class hint_table_scoreboard;
		rec_t        recs [MAX_ENTRIES];
		int          count;
		logic [31:0] ttl;
		res_t        pending [$];
		int          errors;

		function void clear_table();
			foreach (recs[i]) recs[i] = '0;
			count = 0;
		endfunction

		function void reset_all();
			clear_table();
			ttl = TTL_DEFAULT;
			pending.delete();
			errors = 0;
		endfunction

		function int find_key(logic [255:0] nm, logic [47:0] a);
			for (int i = 0; i < count; i++)
				if (recs[i].name == nm && recs[i].addr == a) return i;
			return -1;
		endfunction

		// Predict the result of one accepted operation and advance the shadow table.
		function void note_op(op_t op);
			logic [255:0] nm;
			res_t r;
			int idx, dst, v;
			logic refresh, fresh;
			logic [31:0] cutoff;
			nm = '0;
			for (int b = 0; b < 32; b++) begin
				if (op.name[b*8 +: 8] == 8'd0) break;
				nm[b*8 +: 8] = op.name[b*8 +: 8];
			end
			r = '0;
			r.ok = 1'b1;
			idx = -1;
			case (op.fn)
				F_LOOKUP: begin
					idx = find_key(nm, op.addr);
					r.found = (idx >= 0);
				end
				F_UPSERT: begin
					if (nm[7:0] == 8'd0) begin
						r.ok = 1'b0;
					end else begin
						idx = find_key(nm, op.addr);
						fresh = (idx < 0);
						r.found = !fresh;
						if (fresh) begin
							if (count >= MAX_ENTRIES) begin
								// oldest last-used time goes, lowest index on ties
								v = 0;
								for (int i = 1; i < count; i++)
									if (recs[i].used < recs[v].used) v = i;
								for (int i = v; i + 1 < count; i++) recs[i] = recs[i+1];
								count--;
								recs[count] = '0;
							end
							idx = count;
							count++;
							recs[idx] = '0;
							recs[idx].name = nm;
							recs[idx].addr = op.addr;
						end
						refresh = fresh || recs[idx].flag != op.flag ||
							(op.now > CLOCK_SANE && (op.now - recs[idx].mark) > ttl);
						recs[idx].chan = op.chan;
						recs[idx].flag = op.flag;
						recs[idx].used = op.now;
						if (refresh) recs[idx].mark = op.now;
					end
				end
				F_EVICT: begin
					if (op.now > op.max_age) begin
						cutoff = op.now - op.max_age;
						dst = 0;
						for (int i = 0; i < count; i++) begin
							if (recs[i].used < cutoff) begin
								r.dropped++;
								continue;
							end
							recs[dst] = recs[i];
							dst++;
						end
						for (int i = dst; i < count; i++) recs[i] = '0;
						count = dst;
					end
				end
				default: clear_table();
			endcase
			r.count = COUNT_W'(count);
			if (idx >= 0) begin
				r.slot = SLOT_W'(idx);
				r.chan = recs[idx].chan;
				r.flag = recs[idx].flag;
				r.used = recs[idx].used;
				r.mark = recs[idx].mark;
				r.addr = recs[idx].addr;
			end
			pending.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$error("result with no prediction waiting");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.ok !== e.ok) begin
				$error("ok: expected %0h actual %0h", e.ok, got.ok); errors++;
			end
			if (got.found !== e.found) begin
				$error("found: expected %0h actual %0h", e.found, got.found); errors++;
			end
			if (got.slot !== e.slot) begin
				$error("slot_index: expected %0h actual %0h", e.slot, got.slot); errors++;
			end
			if (got.count !== e.count) begin
				$error("entry_count: expected %0h actual %0h", e.count, got.count); errors++;
			end
			if (got.dropped !== e.dropped) begin
				$error("dropped_count: expected %0h actual %0h", e.dropped, got.dropped);
				errors++;
			end
			if (got.chan !== e.chan) begin
				$error("chan_out: expected %0h actual %0h", e.chan, got.chan); errors++;
			end
			if (got.flag !== e.flag) begin
				$error("flag_out: expected %0h actual %0h", e.flag, got.flag); errors++;
			end
			if (got.used !== e.used) begin
				$error("used_secs_out: expected %0h actual %0h", e.used, got.used); errors++;
			end
			if (got.mark !== e.mark) begin
				$error("mark_secs_out: expected %0h actual %0h", e.mark, got.mark); errors++;
			end
			if (got.addr !== e.addr) begin
				$error("addr_out: expected %0h actual %0h", e.addr, got.addr); errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_wr_en;
	logic [31:0]  cfg_wr_data;
	logic         in_valid;
	logic         in_stall;
	logic [1:0]   func;
	logic [63:0]  name_word0, name_word1, name_word2, name_word3;
	logic [47:0]  station_addr;
	logic [7:0]   chan_in;
	logic         flag_in;
	logic [31:0]  now_secs;
	logic [31:0]  max_age_secs;
	logic         out_valid;
	logic         out_stall;
	logic         ok, found, flag_out;
	logic [2:0]   slot_index;
	logic [3:0]   entry_count, dropped_count;
	logic [7:0]   chan_out;
	logic [31:0]  used_secs_out, mark_secs_out;
	logic [47:0]  addr_out;

	hint_table_scoreboard sb;
	// Idling is switched off for a long stretch in the middle of the random part.
	bit          calm;
	int          sent;
	// Small pools so that keys repeat and lookups and updates actually hit.
	logic [255:0] name_pool [6];
	logic [47:0]  addr_pool [3];
	logic [31:0]  clock_base;

	keyed_lru_hint_table_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.name_word0   (name_word0),
		.name_word1   (name_word1),
		.name_word2   (name_word2),
		.name_word3   (name_word3),
		.station_addr (station_addr),
		.chan_in      (chan_in),
		.flag_in      (flag_in),
		.now_secs     (now_secs),
		.max_age_secs (max_age_secs),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.found        (found),
		.slot_index   (slot_index),
		.entry_count  (entry_count),
		.dropped_count(dropped_count),
		.chan_out     (chan_out),
		.flag_out     (flag_out),
		.used_secs_out(used_secs_out),
		.mark_secs_out(mark_secs_out),
		.addr_out     (addr_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard ceiling, far above what ~1400 items need.
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: random stall, and every output transfer goes to the scoreboard.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result('{ok, found, slot_index, entry_count, dropped_count,
					chan_out, flag_out, used_secs_out, mark_secs_out, addr_out});
			out_stall <= !calm && ($urandom_range(99) < 29);
		end
	end

	// Present one operation and hold it until the input transfer happens.
	// Valid stays up after the transfer; an idle gap or a drain drops it.
	task automatic send_op(op_t op);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= op.fn;
		name_word0   <= op.name[63:0];
		name_word1   <= op.name[127:64];
		name_word2   <= op.name[191:128];
		name_word3   <= op.name[255:192];
		station_addr <= op.addr;
		chan_in      <= op.chan;
		flag_in      <= op.flag;
		now_secs     <= op.now;
		max_age_secs <= op.max_age;
		do @(posedge clk); while (in_stall);
		sb.note_op(op);
		sent++;
	endtask

	// Hold off until every predicted result has come back, then let the
	// sequencer settle.
	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// Register writes happen only with the table idle.
	task automatic write_ttl(logic [31:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.ttl = v;
	endtask

	function automatic logic [255:0] rand_name();
		logic [255:0] n;
		int len;
		n = '0;
		len = $urandom_range(1, 32);
		for (int b = 0; b < len; b++) n[b*8 +: 8] = 8'($urandom_range(1, 255));
		// junk after a terminator must be ignored by the compare
		if ($urandom_range(3) == 0)
			for (int b = len + 1; b < 32; b++) n[b*8 +: 8] = 8'($urandom);
		return n;
	endfunction

	function automatic op_t make_op(func_t fn, logic [255:0] nm, logic [47:0] a,
		logic [7:0] ch, logic fl, logic [31:0] t, logic [31:0] ma);
		op_t o;
		o.fn = fn; o.name = nm; o.addr = a; o.chan = ch;
		o.flag = fl; o.now = t; o.max_age = ma;
		return o;
	endfunction

	// Mostly keyed traffic from the pools with moving time; some pure noise.
	function automatic op_t rand_op();
		op_t o;
		int p;
		p = $urandom_range(99);
		o.fn      = (p < 40) ? F_UPSERT : (p < 80) ? F_LOOKUP : (p < 95) ? F_EVICT : F_CLEAR;
		o.name    = ($urandom_range(9) == 0) ? {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom} : name_pool[$urandom_range(5)];
		if ($urandom_range(29) == 0) o.name[7:0] = 8'd0;
		o.addr    = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
			addr_pool[$urandom_range(2)];
		o.chan    = 8'($urandom);
		o.flag    = 1'($urandom);
		clock_base = clock_base + $urandom_range(0, 200000);
		o.now     = ($urandom_range(19) == 0) ? $urandom : clock_base;
		o.max_age = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 1000000);
		return o;
	endfunction

	initial begin
		logic [255:0] nm_a, nm_b;
		sb = new();
		sb.reset_all();
		calm = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		func = F_LOOKUP;
		{name_word0, name_word1, name_word2, name_word3} = '0;
		station_addr = '0;
		chan_in = '0;
		flag_in = 1'b0;
		now_secs = '0;
		max_age_secs = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table lookup, empty-name rejection, full-width keys.
		nm_a = {256{1'b1}};
		nm_b = 256'h41;
		send_op(make_op(F_LOOKUP, nm_a, '1, 8'hFF, 1'b1, '1, '1));
		send_op(make_op(F_UPSERT, 256'h0, 48'h1, 8'h12, 1'b1, 32'd5, '0));
		send_op(make_op(F_UPSERT, {255'h0, 1'b0} | (256'hFF << 8), 48'h1, 8'h1, 1'b0, 32'd5, '0));
		send_op(make_op(F_UPSERT, nm_a, '1, 8'hFF, 1'b1, '1, '0));
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h00, 1'b0, '0, '0));
		send_op(make_op(F_LOOKUP, nm_a, '1, 8'h0, 1'b0, '0, '0));
		// same key, flag changes, then clock-sane TTL refresh and no refresh
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h33, 1'b1, 32'd1700000100, '0));
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h34, 1'b1, 32'd1700604901, '0));
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h35, 1'b1, 32'd1700604950, '0));
		// a name with junk past the terminator matches the clean name
		send_op(make_op(F_LOOKUP, nm_b | (256'hAB << 24), '0, 8'h0, 1'b0, '0, '0));
		// fill past capacity: LRU eviction with ties on used time
		for (int i = 0; i < 10; i++)
			send_op(make_op(F_UPSERT, 256'h50 + i, 48'(i), 8'(i), 1'b0,
				32'(i % 3), '0));
		send_op(make_op(F_EVICT, '0, '0, '0, 1'b0, 32'd10, 32'd10));
		send_op(make_op(F_EVICT, '0, '0, '0, 1'b0, 32'd3, 32'd1));
		send_op(make_op(F_EVICT, '0, '0, '0, 1'b0, '1, '0));
		send_op(make_op(F_CLEAR, '0, '0, '0, 1'b0, '0, '0));

		// Register extremes with clock-sane traffic in between.
		write_ttl('0);
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h1, 1'b0, 32'd1800000000, '0));
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h2, 1'b0, 32'd1800000001, '0));
		write_ttl('1);
		send_op(make_op(F_UPSERT, nm_b, '0, 8'h3, 1'b0, '1, '0));

		for (int i = 0; i < 6; i++) name_pool[i] = rand_name();
		for (int i = 0; i < 3; i++) addr_pool[i] = 48'({$urandom, $urandom});
		clock_base = 32'd1699000000;

		// Random phases, each under a different TTL setting.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_ttl(TTL_DEFAULT);
				1: write_ttl($urandom_range(0, 300000));
				2: write_ttl(32'd1);
				default: write_ttl($urandom);
			endcase
			calm = (ph == 2);
			for (int i = 0; i < 345; i++) begin
				if (i == 170) drain();
				if ($urandom_range(49) == 0) name_pool[$urandom_range(5)] = rand_name();
				send_op(rand_op());
			end
			calm = 1'b0;
		end

		drain();
		$display("Covered %0d operations: lookups, upserts with LRU eviction,", sent);
		$display("stale eviction, clears and four mark TTL settings.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/klht_pkg.sv
src/klht_ram.sv
src/keyed_lru_hint_table_top.sv
src/klht_chk.sv
tb/sv/tb_keyed_lru_hint_table_top.sv
